// ===== design/isn_pkg.sv =====
// package for the interval set normalizer: defaults and controller states
`timescale 1ns / 1ps
`default_nettype none
package isn_pkg;
   localparam int unsigned MaxIntervalsDefault = 64;
   localparam int unsigned CoordBitsDefault    = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DR_START,
      ST_DR_LOAD,
      ST_DR_CMP,
      ST_DR_FIN
   } isn_state_type;
endpackage
`default_nettype wire

// ===== design/interval_set_normalize_core.sv =====
// interval set normalizer top level: sorted store in memory, merge on drain
//
// Input channel req_*: one interval per transfer (row, x_start, x_end, last_in).
// Each interval is insertion-sorted into a single-port-write, one-read memory
// by row then start x. Insertion walks down from the top of the store one
// entry per cycle, moving each stored entry that sorts after it up a slot.
// A full store drops the interval in its transfer cycle and sets the
// overflow flag. When last_in is set, the store is read back entry by entry
// (one read a cycle except while a closed run waits on a stalled receiver,
// registered read data), runs on the same row that touch or overlap are
// merged, and each merged run leaves on the rsp_* channel. The final run is
// valid on rsp_* in the cycle the block returns to idle.
// req_ready is high only while the block is idle; a stalled receiver holds
// the drain in place with the pending run kept in registers.
// Synchronous active-high reset empties the store (count and overflow flag
// cleared); memory contents are not cleared and are never read unwritten.
`timescale 1ns / 1ps
`default_nettype none
module interval_set_normalize_core
   import isn_pkg::*;
#(
   parameter int unsigned MAX_INTERVALS = MaxIntervalsDefault,
   parameter int unsigned COORD_BITS    = CoordBitsDefault
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire signed [COORD_BITS-1:0]  req_row,
   input  wire signed [COORD_BITS-1:0]  req_x_start,
   input  wire signed [COORD_BITS-1:0]  req_x_end,
   input  wire                          req_last_in,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_out_row,
   output logic signed [COORD_BITS-1:0] rsp_out_start,
   output logic signed [COORD_BITS-1:0] rsp_out_end,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow
);
   localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
   localparam int unsigned EW = 3 * COORD_BITS;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_INTERVALS);
   localparam logic [CW-1:0] One      = CW'(1);

   logic [EW-1:0] mem [MAX_INTERVALS];
   logic [EW-1:0] rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata;

   isn_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, idx_ff, idx_in;
   logic          ovf_ff, ovf_in, last_ff, last_in;
   logic [EW-1:0] new_ff, new_in;
   logic signed [COORD_BITS-1:0] run_row_ff, run_row_in, run_xs_ff, run_xs_in;
   logic signed [COORD_BITS-1:0] run_xe_ff, run_xe_in;
   logic          rv_ff, rv_in, rl_ff, rl_in, ro_ff, ro_in;
   logic signed [COORD_BITS-1:0] rrow_ff, rrow_in, rxs_ff, rxs_in, rxe_ff, rxe_in;

   logic signed [COORD_BITS-1:0] rd_row, rd_xs, rd_xe, nw_row, nw_xs;
   logic out_free, goes_after, merges;

   assign rd_row = rdata_ff[EW-1 -: COORD_BITS];
   assign rd_xs  = rdata_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign rd_xe  = rdata_ff[COORD_BITS-1:0];
   assign nw_row = new_ff[EW-1 -: COORD_BITS];
   assign nw_xs  = new_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign goes_after = (rd_row > nw_row) || ((rd_row == nw_row) && (rd_xs > nw_xs));
   assign merges     = (rd_row == run_row_ff) && (rd_xs <= run_xe_ff);
   assign out_free   = !rv_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      last_ff    <= last_in;
      new_ff     <= new_in;
      run_row_ff <= run_row_in;
      run_xs_ff  <= run_xs_in;
      run_xe_ff  <= run_xe_in;
      rl_ff      <= rl_in;
      ro_ff      <= ro_in;
      rrow_ff    <= rrow_in;
      rxs_ff     <= rxs_in;
      rxe_ff     <= rxe_in;
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      last_in    = last_ff;
      new_in     = new_ff;
      run_row_in = run_row_ff;
      run_xs_in  = run_xs_ff;
      run_xe_in  = run_xe_ff;
      rv_in      = rv_ff && !rsp_ready;
      rl_in      = rl_ff;
      ro_in      = ro_ff;
      rrow_in    = rrow_ff;
      rxs_in     = rxs_ff;
      rxe_in     = rxe_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = pos_ff[AW-1:0];
      mem_raddr  = '0;
      mem_wdata  = new_ff;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               new_in  = {req_row, req_x_start, req_x_end};
               last_in = req_last_in;
               pos_in  = cnt_ff;
               if (cnt_ff == MaxCount) begin
                  ovf_in   = 1'b1;
                  state_in = req_last_in ? ST_DR_START : ST_IDLE;
               end else if (cnt_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  // look at the entry just below the free slot
                  mem_re    = 1'b1;
                  mem_raddr = AW'(cnt_ff - One);
                  state_in  = ST_INS_CMP;
               end
            end
         end
         ST_INS_CMP: begin
            if (goes_after) begin
               // shift the entry up one slot and keep walking down
               mem_we    = 1'b1;
               mem_wdata = rdata_ff;
               pos_in    = pos_ff - One;
               if (pos_ff == One) begin
                  state_in = ST_INS_PUT;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(pos_ff - CW'(2));
               end
            end else begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + One;
               state_in = last_ff ? ST_DR_START : ST_IDLE;
            end
         end
         ST_INS_PUT: begin
            mem_we   = 1'b1;
            cnt_in   = cnt_ff + One;
            state_in = last_ff ? ST_DR_START : ST_IDLE;
         end
         ST_DR_START: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            idx_in    = One;
            state_in  = ST_DR_LOAD;
         end
         ST_DR_LOAD: begin
            run_row_in = rd_row;
            run_xs_in  = rd_xs;
            run_xe_in  = rd_xe;
            if (idx_ff < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[AW-1:0];
               idx_in    = idx_ff + One;
               state_in  = ST_DR_CMP;
            end else begin
               state_in = ST_DR_FIN;
            end
         end
         ST_DR_CMP: begin
            if (merges || out_free) begin
               if (merges) begin
                  if (rd_xe > run_xe_ff) run_xe_in = rd_xe;
               end else begin
                  // close the current run and open one at this entry
                  rv_in      = 1'b1;
                  rl_in      = 1'b0;
                  ro_in      = ovf_ff;
                  rrow_in    = run_row_ff;
                  rxs_in     = run_xs_ff;
                  rxe_in     = run_xe_ff;
                  run_row_in = rd_row;
                  run_xs_in  = rd_xs;
                  run_xe_in  = rd_xe;
               end
               if (idx_ff < cnt_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff[AW-1:0];
                  idx_in    = idx_ff + One;
               end else begin
                  state_in = ST_DR_FIN;
               end
            end
         end
         ST_DR_FIN: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rl_in    = 1'b1;
               ro_in    = ovf_ff;
               rrow_in  = run_row_ff;
               rxs_in   = run_xs_ff;
               rxe_in   = run_xe_ff;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_row   = rrow_ff;
   assign rsp_out_start = rxs_ff;
   assign rsp_out_end   = rxe_ff;
   assign rsp_last_out  = rl_ff;
   assign rsp_overflow  = ro_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= MaxCount)
      else $error("stored count beyond capacity");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DR_CMP) |-> (idx_ff <= cnt_ff))
      else $error("drain index beyond stored count");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DR_FIN && out_free) |=> (cnt_ff == '0 && !ovf_ff && rsp_last_out))
      else $error("store not emptied after final run");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CMP) |-> (pos_ff != '0 && pos_ff <= cnt_ff))
      else $error("insertion slot out of range");
endmodule
`default_nettype wire

// ===== bench/interval_set_normalize_core_tb.sv =====
// testbench for the interval set normalizer: directed table plus random sets
`timescale 1ns / 1ps
`default_nettype none
module interval_set_normalize_core_tb
   import isn_pkg::*;
();

   localparam int unsigned Depth = MaxIntervalsDefault;
   localparam int unsigned CBits = CoordBitsDefault;
   localparam int unsigned IdleLimit = 20000;

   typedef logic signed [CBits-1:0] coord_type;

   typedef struct packed {
      coord_type row;
      coord_type xs;
      coord_type xe;
      logic      last;
   } span_type;

   typedef struct packed {
      coord_type row;
      coord_type xs;
      coord_type xe;
      logic      last;
      logic      ovf;
   } run_type;

   // directed row: interval, and optionally a typed-in expected run
   typedef struct packed {
      span_type span;
      logic     has_run;
      run_type  run;
   } drow_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_row = '0;
   coord_type req_x_start = '0;
   coord_type req_x_end = '0;
   logic      req_last_in = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_out_row;
   coord_type rsp_out_start;
   coord_type rsp_out_end;
   logic      rsp_last_out;
   logic      rsp_overflow;

   interval_set_normalize_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_row(req_row), .req_x_start(req_x_start), .req_x_end(req_x_end),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_row(rsp_out_row), .rsp_out_start(rsp_out_start),
      .rsp_out_end(rsp_out_end), .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow)
   );

   always #5 clock = ~clock;

   // predictor state: sorted store, fill count, drop flag
   span_type sorted_spans[$];
   logic     dropped = 1'b0;
   run_type  pending_runs[$];
   run_type  typed_runs[$];
   int       errors = 0;
   int       runs_seen = 0;
   int       sent = 0;
   int       idle_cycles = 0;
   bit       quiet_recv = 1'b0;
   bit       quiet_send = 1'b0;

   function automatic void merge_span(span_type s);
      int      pos;
      run_type cur;
      if (sorted_spans.size() < Depth) begin
         pos = sorted_spans.size();
         while (pos > 0 && (sorted_spans[pos-1].row > s.row ||
               (sorted_spans[pos-1].row == s.row && sorted_spans[pos-1].xs > s.xs)))
            pos--;
         sorted_spans.insert(pos, s);
      end else begin
         dropped = 1'b1;
      end
      if (!s.last) return;
      cur = '{sorted_spans[0].row, sorted_spans[0].xs, sorted_spans[0].xe, 1'b0, dropped};
      for (int i = 1; i < sorted_spans.size(); i++) begin
         if (sorted_spans[i].row == cur.row && sorted_spans[i].xs <= cur.xe) begin
            if (sorted_spans[i].xe > cur.xe) cur.xe = sorted_spans[i].xe;
         end else begin
            pending_runs.insert(pending_runs.size(), cur);
            cur = '{sorted_spans[i].row, sorted_spans[i].xs, sorted_spans[i].xe,
                    1'b0, dropped};
         end
      end
      cur.last = 1'b1;
      pending_runs.insert(pending_runs.size(), cur);
      sorted_spans.delete();
      dropped = 1'b0;
   endfunction

   // sample at rising edge: predict accepted intervals, check results
   always @(posedge clock) begin
      run_type got;
      run_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            merge_span('{req_row, req_x_start, req_x_end, req_last_in});
            sent++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_row, rsp_out_start, rsp_out_end, rsp_last_out, rsp_overflow};
            runs_seen++;
            if (pending_runs.size() == 0) begin
               $display("%0t: unexpected run %p", $time, got);
               errors++;
            end else begin
               want = pending_runs.pop_front();
               if (got.row !== want.row || got.xs !== want.xs || got.xe !== want.xe ||
                   got.last !== want.last || got.ovf !== want.ovf) begin
                  $display("%0t: run mismatch expected %p actual %p", $time, want, got);
                  errors++;
               end
               if (typed_runs.size() != 0) begin
                  want = typed_runs.pop_front();
                  if (got !== want) begin
                     $display("%0t: table mismatch expected %p actual %p",
                              $time, want, got);
                     errors++;
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= quiet_recv ? 1'b1 : ($urandom_range(99) >= 31);
   end

   // valid drops only while idling, so back-to-back transfers keep it high
   task automatic send_span(span_type s);
      while (!quiet_send && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_row     <= s.row;
      req_x_start <= s.xs;
      req_x_end   <= s.xe;
      req_last_in <= s.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic span_type rand_span(int nrows, int spread, logic last);
      span_type s;
      s.row  = coord_type'($urandom_range(nrows - 1)) - coord_type'(nrows / 2);
      s.xs   = coord_type'($urandom_range(spread)) - coord_type'(spread / 2);
      s.xe   = s.xs + coord_type'($urandom_range(12)) - coord_type'(2);
      s.last = last;
      if ($urandom_range(9) == 0) begin
         s.row = coord_type'($urandom);
         s.xs  = coord_type'($urandom);
         s.xe  = coord_type'($urandom);
      end
      return s;
   endfunction

   localparam coord_type CMin = {1'b1, {(CBits-1){1'b0}}};
   localparam coord_type CMax = {1'b0, {(CBits-1){1'b1}}};

   drow_type steps[$];

   function automatic void add_step(drow_type d);
      steps.insert(steps.size(), d);
   endfunction

   initial begin
      int n;
      int len;
      int sets = 0;
      // single extreme intervals, each a closed set with a known result
      add_step('{'{CMin, CMin, CMax, 1'b1}, 1'b1, '{CMin, CMin, CMax, 1'b1, 1'b0}});
      add_step('{'{CMax, CMax, CMin, 1'b1}, 1'b1, '{CMax, CMax, CMin, 1'b1, 1'b0}});
      add_step('{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1,
                 '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0}});
      add_step('{'{16'sh5555, 16'shAAAA, 16'sh5555, 1'b1}, 1'b1,
                 '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, 1'b0}});
      // touching, overlapping, contained, inverted, and separate runs
      add_step('{'{16'sd3, 16'sd10, 16'sd20, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, 16'sd20, 16'sd25, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, 16'sd12, 16'sd14, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, 16'sd22, 16'sd5, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, 16'sd40, 16'sd50, 1'b0}, 1'b0, '0});
      add_step('{'{-16'sd1, 16'sd40, 16'sd30, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, -16'sd5, 16'sd10, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd2, 16'sd0, 16'sd1, 1'b0}, 1'b0, '0});
      add_step('{'{16'sd3, 16'sd10, 16'sd11, 1'b1}, 1'b0, '0});
      foreach (steps[i])
         if (steps[i].has_run) typed_runs.insert(typed_runs.size(), steps[i].run);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      dropped = 1'b0;

      foreach (steps[i]) send_span(steps[i].span);
      // overflow: full store then extras, last one dropped too
      for (int i = 0; i < Depth + 3; i++)
         send_span(rand_span(4, 200, i == Depth + 2));
      // random sets, mostly small; a stretch with no stalls in the middle
      while (sent < 320) begin
         quiet_send = (sets >= 8 && sets < 14);
         quiet_recv = quiet_send;
         n = $urandom_range(9);
         len = (n == 0) ? Depth + $urandom_range(4) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++)
            send_span(rand_span(n < 3 ? 2 : 6, n < 5 ? 40 : 400, i == len - 1));
         sets++;
      end
      req_valid <= 1'b0;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;

      n = 0;
      while (pending_runs.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      $display("sent %0d intervals in %0d random sets, checked %0d merged runs",
               sent, sets, runs_seen);
      if (errors == 0 && pending_runs.size() == 0 && typed_runs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d runs still expected", pending_runs.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
